/* design/multi_duration_key_classifier_top_macros.svh */
// Assertion macros shared by the classifier's top level.
`ifndef MULTI_DURATION_KEY_CLASSIFIER_TOP_MACROS_SVH
`define MULTI_DURATION_KEY_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define MDKC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MDKC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/mdkc_pkg.sv */
// Shared types and constants of the multi-duration key classifier.
`default_nettype none
package mdkc_pkg;

	localparam int CfgW               = 16;
	localparam int TIMER_BITS_DEFAULT = 16;
	localparam int PaddrW             = 4;
	localparam int PdataW             = 32;
	localparam int ElapsedW           = 8;

	// Key state machine phases, as reported on key_phase
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WAIT    = 3'd1,
		PH_RECEIPT = 3'd2,
		PH_RESET   = 3'd3,
		PH_CHECK   = 3'd4,
		PH_RELEASE = 3'd5
	} phase_t;

	// Event codes
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_RECEIPT = 2'd1,
		EV_RESET   = 2'd2,
		EV_CHECK   = 2'd3
	} event_t;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_RECEIPT_HOLD = 2'd0;
	localparam logic [1:0] REG_RESET_HOLD   = 2'd1;
	localparam logic [1:0] REG_CHECK_HOLD   = 2'd2;

	localparam logic [CfgW-1:0] RECEIPT_HOLD_RST = 16'd5;
	localparam logic [CfgW-1:0] RESET_HOLD_RST   = 16'd300;
	localparam logic [CfgW-1:0] CHECK_HOLD_RST   = 16'd500;

	typedef struct packed {
		logic [CfgW-1:0] receipt_hold_ticks;
		logic [CfgW-1:0] reset_hold_ticks;
		logic [CfgW-1:0] check_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] event_code;
		logic [2:0] key_phase;
	} result_t;

	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} buf_status_t;

endpackage
`default_nettype wire

/* design/mdkc_poll_if.sv */
// Poll channel: one key sample per transfer.
`default_nettype none
interface mdkc_poll_if;
	logic       valid;
	logic       ready;
	logic       key_pressed;
	logic [7:0] elapsed_ticks;
	logic [1:0] query_code;

	modport source (output valid, key_pressed, elapsed_ticks, query_code, input ready);
	modport sink   (input valid, key_pressed, elapsed_ticks, query_code, output ready);
endinterface
`default_nettype wire

/* design/mdkc_result_if.sv */
// Result channel: one classification result per transfer.
`default_nettype none
interface mdkc_result_if;
	logic       valid;
	logic       ready;
	logic       matched;
	logic [1:0] event_code;
	logic [2:0] key_phase;

	modport source (output valid, matched, event_code, key_phase, input ready);
	modport sink   (input valid, matched, event_code, key_phase, output ready);
endinterface
`default_nettype wire

/* design/mdkc_cfg_regs.sv */
// APB-style hold-time registers.
`default_nettype none
module mdkc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mdkc_pkg::PaddrW-1:0] paddr,
	input  logic [mdkc_pkg::PdataW-1:0] pwdata,
	output logic [mdkc_pkg::PdataW-1:0] prdata,
	output logic                       pready,
	output mdkc_pkg::cfg_t             cfg
);
	import mdkc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register write; index three is not decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.receipt_hold_ticks <= RECEIPT_HOLD_RST;
			cfg_q.reset_hold_ticks   <= RESET_HOLD_RST;
			cfg_q.check_hold_ticks   <= CHECK_HOLD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RECEIPT_HOLD: cfg_q.receipt_hold_ticks <= pwdata[CfgW-1:0];
				REG_RESET_HOLD:   cfg_q.reset_hold_ticks   <= pwdata[CfgW-1:0];
				REG_CHECK_HOLD:   cfg_q.check_hold_ticks   <= pwdata[CfgW-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_RECEIPT_HOLD: prdata = PdataW'(cfg_q.receipt_hold_ticks);
			REG_RESET_HOLD:   prdata = PdataW'(cfg_q.reset_hold_ticks);
			REG_CHECK_HOLD:   prdata = PdataW'(cfg_q.check_hold_ticks);
			default:          prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

/* design/mdkc_core.sv */
// Key state machine, countdown timer and event latch; one step per poll.
`default_nettype none
module mdkc_core #(
	parameter int TIMER_BITS = mdkc_pkg::TIMER_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         key_pressed,
	input  logic [mdkc_pkg::ElapsedW-1:0] elapsed_ticks,
	input  logic [1:0]                   query_code,
	input  mdkc_pkg::cfg_t               cfg,
	output mdkc_pkg::result_t            res
);
	import mdkc_pkg::*;

	localparam int WideW = (TIMER_BITS > CfgW) ? TIMER_BITS : CfgW;
	localparam logic [WideW-1:0] TimerMax = WideW'({TIMER_BITS{1'b1}});

	phase_t                phase_q, phase_n;
	logic [TIMER_BITS-1:0] rem_q, rem_n, rem_dec;
	logic [1:0]            pend_q, pend_n;
	logic [1:0]            latch_q, latch_n;
	logic [1:0]            evt;
	logic                  ovf;
	logic                  hit;

	// hold time clipped to the timer range
	function automatic logic [TIMER_BITS-1:0] load_dur(input logic [CfgW-1:0] v);
		logic [WideW-1:0] vw;
		vw = WideW'(v);
		return (vw > TimerMax) ? TimerMax[TIMER_BITS-1:0] : vw[TIMER_BITS-1:0];
	endfunction

	// saturating countdown
	assign rem_dec = (rem_q > TIMER_BITS'(elapsed_ticks)) ?
		rem_q - TIMER_BITS'(elapsed_ticks) : '0;
	assign ovf = (rem_dec == '0);

	// next state
	always_comb begin
		phase_n = phase_q;
		rem_n   = rem_dec;
		pend_n  = pend_q;
		latch_n = latch_q;
		case (phase_q)
			PH_WAIT: begin
				if (key_pressed) begin
					rem_n   = load_dur(cfg.receipt_hold_ticks);
					phase_n = PH_RECEIPT;
				end
			end
			PH_RECEIPT, PH_RESET, PH_CHECK: begin
				if (!key_pressed) begin
					latch_n = pend_q;
					phase_n = PH_IDLE;
				end else if (ovf) begin
					case (phase_q)
						PH_RECEIPT: begin
							rem_n   = load_dur(cfg.reset_hold_ticks);
							pend_n  = EV_RECEIPT;
							phase_n = PH_RESET;
						end
						PH_RESET: begin
							rem_n   = load_dur(cfg.check_hold_ticks);
							pend_n  = EV_RESET;
							phase_n = PH_CHECK;
						end
						default: begin
							pend_n  = EV_CHECK;
							phase_n = PH_RELEASE;
						end
					endcase
					latch_n = pend_n;
				end
			end
			PH_RELEASE: begin
				if (!key_pressed) begin
					phase_n = PH_IDLE;
				end
			end
			default: begin
				latch_n = pend_q;
				phase_n = PH_WAIT;
			end
		endcase

		// query against the freshly latched event
		evt = latch_n;
		hit = (evt == query_code);
		if (hit) begin
			latch_n = EV_NONE;
			pend_n  = EV_NONE;
		end

		res.matched    = hit;
		res.event_code = evt;
		res.key_phase  = phase_n;
	end

	// state registers advance once per accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rem_q   <= '0;
			pend_q  <= EV_NONE;
			latch_q <= EV_NONE;
		end else if (step) begin
			phase_q <= phase_n;
			rem_q   <= rem_n;
			pend_q  <= pend_n;
			latch_q <= latch_n;
		end
	end
endmodule
`default_nettype wire

/* design/mdkc_out_buf.sv */
// Result register with a skid entry, so a poll is taken while a result waits.
`default_nettype none
module mdkc_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mdkc_pkg::result_t     push_data,
	output logic                  can_push,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mdkc_pkg::result_t     out_data,
	output mdkc_pkg::buf_status_t status
);
	import mdkc_pkg::*;

	logic    main_v_q, skid_v_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop       = main_v_q & out_ready;
	assign can_push  = ~skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign status    = '{main_valid: main_v_q, skid_valid: skid_v_q};

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end
endmodule
`default_nettype wire

/* design/multi_duration_key_classifier_top.sv */
// Top level of the multi-duration key classifier.
`default_nettype none
`include "multi_duration_key_classifier_top_macros.svh"
// Long-press classifier: each poll transfer (key level, ticks elapsed, query code) steps a
// saturating countdown and the key state machine, and yields exactly one result transfer
// (matched, latched event, phase). A poll is taken every clock while poll ready is high;
// the whole step is one pass of logic into the state and result registers. A two-entry
// result buffer lets one further poll be taken while a result is stalled; poll ready drops
// only when both entries are full. Hold times are written over APB at byte addresses 0, 4
// and 8; the user must write them only while no poll is in flight; it is not enforced.
module multi_duration_key_classifier_top #(
	parameter int TIMER_BITS = mdkc_pkg::TIMER_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mdkc_poll_if.sink                   poll,
	mdkc_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mdkc_pkg::PaddrW-1:0] paddr,
	input  logic [mdkc_pkg::PdataW-1:0] pwdata,
	output logic [mdkc_pkg::PdataW-1:0] prdata,
	output logic                        pready
);
	import mdkc_pkg::*;

	cfg_t        cfg;
	result_t     step_res;
	result_t     out_res;
	buf_status_t stat;
	logic        can_push;
	logic        poll_xfer;
	logic        main_v;
	logic        skid_v;
	logic        out_stall;

	assign poll.ready = can_push;
	assign poll_xfer  = poll.valid & can_push;

	mdkc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mdkc_core #(.TIMER_BITS(TIMER_BITS)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (poll_xfer),
		.key_pressed   (poll.key_pressed),
		.elapsed_ticks (poll.elapsed_ticks),
		.query_code    (poll.query_code),
		.cfg           (cfg),
		.res           (step_res)
	);

	mdkc_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (poll_xfer),
		.push_data (step_res),
		.can_push  (can_push),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_res),
		.status    (stat)
	);

	assign result.matched    = out_res.matched;
	assign result.event_code = out_res.event_code;
	assign result.key_phase  = out_res.key_phase;

	// buffer occupancy seen by the checks
	assign main_v    = stat.main_valid;
	assign skid_v    = stat.skid_valid;
	assign out_stall = main_v & ~result.ready;

	// buffer bookkeeping checks
	`MDKC_ASSERT_NOW(a_skid_needs_main, skid_v, main_v, "skid full while main empty")
	`MDKC_ASSERT_NEXT(a_poll_to_result, poll_xfer && !main_v, main_v, "result lost")
	`MDKC_ASSERT_NEXT(a_stall_to_skid, poll_xfer && out_stall, skid_v, "stalled result lost")
endmodule
`default_nettype wire
